// ----- sv/dtt_pkg.sv -----
// ============================================================================
// dtt_pkg : shared types and constants for the dictionary text tokenizer
// Token kinds, scanner modes, literal tables and the command/status structs
// that join the controller, the datapath and the result stage.
// ============================================================================
package dtt_pkg;

   // Literal dictionary
   localparam int LONGEST_LITERAL = 14;
   localparam int CNT_W           = $clog2(LONGEST_LITERAL + 1);
   localparam int NUM_LIT         = 4;

   localparam logic [8*LONGEST_LITERAL-1:0] LIT_DICT_TEXT  = "<dictionary> {";
   localparam logic [8*LONGEST_LITERAL-1:0] LIT_ARRAY_TEXT = "<array> {";
   localparam logic [8*LONGEST_LITERAL-1:0] LIT_COLON_TEXT = " : ";
   localparam logic [8*LONGEST_LITERAL-1:0] LIT_NOKEY_TEXT = "  No such key\n";

   // Characters the scanner tests for
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [3:0] {
      TK_DICT    = 4'd0,
      TK_ARRAY   = 4'd1,
      TK_CLOSE   = 4'd2,
      TK_COLON   = 4'd3,
      TK_IDENT   = 4'd4,
      TK_NEWLINE = 4'd5,
      TK_NOKEY   = 4'd6,
      TK_END     = 4'd7,
      TK_ERROR   = 4'd8
   } tok_kind_type;

   typedef enum logic [1:0] {
      LIT_DICT  = 2'd0,
      LIT_ARRAY = 2'd1,
      LIT_COLON = 2'd2,
      LIT_NOKEY = 2'd3
   } lit_idx_type;

   typedef enum logic [2:0] {
      SM_FIRST   = 3'd0,
      SM_START   = 3'd1,
      SM_MATCH   = 3'd2,
      SM_IDENT   = 3'd3,
      SM_SWALLOW = 3'd4,
      SM_HALT    = 3'd5
   } scan_mode_type;

   // Operation on the partial-literal registers
   typedef enum logic [2:0] {
      MOP_NONE        = 3'd0,
      MOP_BEGIN_LT    = 3'd1,
      MOP_BEGIN_SP    = 3'd2,
      MOP_BEGIN_NOKEY = 3'd3,
      MOP_ADVANCE     = 3'd4,
      MOP_CLEAR       = 3'd5,
      MOP_REPLAY      = 3'd6
   } match_op_type;

   // Source of the ident_char field of a result
   typedef enum logic [1:0] {
      CS_NONE  = 2'd0,
      CS_VALUE = 2'd1,
      CS_LT    = 2'd2
   } char_sel_type;

   // Per-step decision of the controller
   typedef struct packed {
      logic         consume;
      logic         emit;
      tok_kind_type kind;
      char_sel_type char_sel;
      match_op_type mop;
   } step_op_type;

   typedef struct packed {
      logic        load;
      logic        step;
      step_op_type op;
   } ctl_cmd_type;

   // Datapath status: class of the current value and matcher outcome
   typedef struct packed {
      logic         val_end;
      logic         val_ws;
      logic         val_lt;
      logic         val_space;
      logic         val_rbrace;
      logic         val_lf;
      logic         match_hit;
      logic         match_done;
      tok_kind_type match_kind;
      logic         from_lt;
      logic         replaying;
   } dp_sts_type;

   typedef struct packed {
      tok_kind_type token_kind;
      logic [7:0]   ident_char;
      logic         char_valid;
      logic         token_done;
      logic         last;
   } rsp_item_type;

   function automatic logic [CNT_W-1:0] lit_len(input lit_idx_type idx);
      logic [CNT_W-1:0] len;
      unique case (idx)
         LIT_DICT:  len = CNT_W'(14);
         LIT_ARRAY: len = CNT_W'(9);
         LIT_COLON: len = CNT_W'(3);
         LIT_NOKEY: len = CNT_W'(14);
         default:   len = '0;
      endcase
      return len;
   endfunction

   function automatic tok_kind_type lit_kind(input lit_idx_type idx);
      tok_kind_type kind;
      unique case (idx)
         LIT_DICT:  kind = TK_DICT;
         LIT_ARRAY: kind = TK_ARRAY;
         LIT_COLON: kind = TK_COLON;
         LIT_NOKEY: kind = TK_NOKEY;
         default:   kind = TK_ERROR;
      endcase
      return kind;
   endfunction

   // Character at position pos of a literal; zero past its end
   function automatic logic [7:0] lit_char(input lit_idx_type idx,
                                           input logic [CNT_W-1:0] pos);
      logic [8*LONGEST_LITERAL-1:0] text;
      logic [8*LONGEST_LITERAL-1:0] shifted;
      logic [CNT_W-1:0]             len;
      unique case (idx)
         LIT_DICT:  text = LIT_DICT_TEXT;
         LIT_ARRAY: text = LIT_ARRAY_TEXT;
         LIT_COLON: text = LIT_COLON_TEXT;
         LIT_NOKEY: text = LIT_NOKEY_TEXT;
         default:   text = '0;
      endcase
      len = lit_len(idx);
      if (pos < len) begin
         shifted = text >> (8 * (int'(len) - 1 - int'(pos)));
         return shifted[7:0];
      end
      return 8'h00;
   endfunction

endpackage

// ----- sv/dtt_ctrl.sv -----
// ============================================================================
// dtt_ctrl : tokenizer controller
// Scanner-mode state machine. Decides per step what result to form, what to
// do with the partial literal and whether the current value is used up.
// ============================================================================
module dtt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               stage_ok,
   input  dtt_pkg::dp_sts_type  sts,
   output dtt_pkg::ctl_cmd_type cmd,
   output logic               gen_valid,
   output logic               mark_last
);
   import dtt_pkg::*;

   scan_mode_type mode_ff, mode_in;
   logic          busy_ff, busy_in;
   step_op_type   op;
   logic          step;
   logic          load;
   logic          item_done;
   logic          skip_ws;

   // a held value is processed whenever the result stage can take a result
   assign step      = busy_ff && stage_ok;
   assign item_done = step && op.consume && !sts.replaying;
   assign req_ready = !busy_ff || item_done;
   assign load      = req_valid && req_ready;
   assign gen_valid = step && op.emit;
   assign mark_last = item_done && !op.emit;
   assign skip_ws   = (mode_ff == SM_SWALLOW) && sts.val_ws;

   assign cmd = '{load: load, step: step, op: op};

   // Next state
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         unique case (mode_ff)
            SM_FIRST: begin
               priority if (sts.val_end)                     mode_in = SM_HALT;
               else if (sts.val_lt || sts.val_space)         mode_in = SM_MATCH;
               else                                          mode_in = SM_HALT;
            end
            SM_START, SM_SWALLOW: begin
               priority if (sts.val_end)                     mode_in = SM_FIRST;
               else if (skip_ws)                             mode_in = mode_ff;
               else if (sts.val_lt || sts.val_space)         mode_in = SM_MATCH;
               else if (sts.val_rbrace)                      mode_in = SM_START;
               else if (sts.val_lf)                          mode_in = SM_SWALLOW;
               else if (sts.val_ws)                          mode_in = SM_HALT;
               else                                          mode_in = SM_IDENT;
            end
            SM_MATCH: begin
               priority if (sts.match_hit)
                  mode_in = sts.match_done ? SM_START : SM_MATCH;
               else if (sts.from_lt)                         mode_in = SM_IDENT;
               else                                          mode_in = SM_HALT;
            end
            SM_IDENT: begin
               if (sts.val_end || sts.val_ws) mode_in = SM_START;
            end
            SM_HALT: begin
               if (sts.val_end) mode_in = SM_FIRST;
            end
            default: mode_in = SM_FIRST;
         endcase
      end
      priority if (load)  busy_in = 1'b1;
      else if (item_done) busy_in = 1'b0;
      else                busy_in = busy_ff;
   end

   // Step outputs
   always_comb begin
      op = '{consume: 1'b1, emit: 1'b0, kind: TK_ERROR, char_sel: CS_NONE,
             mop: MOP_NONE};
      unique case (mode_ff)
         SM_FIRST: begin
            // text must open with '<' or the no-key line
            priority if (sts.val_end) begin
               op.emit    = 1'b1;
               op.consume = 1'b0;
            end else if (sts.val_lt) begin
               op.mop = MOP_BEGIN_LT;
            end else if (sts.val_space) begin
               op.mop = MOP_BEGIN_NOKEY;
            end else begin
               op.emit = 1'b1;
            end
         end
         SM_START, SM_SWALLOW: begin
            priority if (sts.val_end) begin
               op.emit = 1'b1;
               op.kind = TK_END;
               op.mop  = MOP_CLEAR;
            end else if (skip_ws) begin
               op.emit = 1'b0;
            end else if (sts.val_lt) begin
               op.mop = MOP_BEGIN_LT;
            end else if (sts.val_space) begin
               op.mop = MOP_BEGIN_SP;
            end else if (sts.val_rbrace) begin
               op.emit = 1'b1;
               op.kind = TK_CLOSE;
            end else if (sts.val_lf) begin
               op.emit = 1'b1;
               op.kind = TK_NEWLINE;
            end else if (sts.val_ws) begin
               op.emit = 1'b1;
            end else begin
               op.emit     = 1'b1;
               op.kind     = TK_IDENT;
               op.char_sel = CS_VALUE;
            end
         end
         SM_MATCH: begin
            priority if (sts.match_hit) begin
               if (sts.match_done) begin
                  op.emit = 1'b1;
                  op.kind = sts.match_kind;
                  op.mop  = MOP_CLEAR;
               end else begin
                  op.mop = MOP_ADVANCE;
               end
            end else if (sts.from_lt) begin
               // failed '<' literal: its bytes restart as an identifier
               op.emit     = 1'b1;
               op.kind     = TK_IDENT;
               op.char_sel = CS_LT;
               op.mop      = MOP_REPLAY;
               op.consume  = 1'b0;
            end else begin
               op.emit    = 1'b1;
               op.mop     = MOP_CLEAR;
               op.consume = 1'b0;
            end
         end
         SM_IDENT: begin
            op.emit = 1'b1;
            op.kind = TK_IDENT;
            if (sts.val_end || sts.val_ws) begin
               // close the identifier, then handle the value at token start
               op.consume = 1'b0;
            end else begin
               op.char_sel = CS_VALUE;
            end
         end
         SM_HALT: begin
            if (sts.val_end) begin
               op.emit = 1'b1;
               op.kind = TK_END;
               op.mop  = MOP_CLEAR;
            end
         end
         default: op.mop = MOP_CLEAR;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= SM_FIRST;
         busy_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- sv/dtt_datapath.sv -----
// ============================================================================
// dtt_datapath : tokenizer datapath
// Holds the accepted byte, the partial-literal match state and the replay
// pointer; classifies the current value and forms each result.
// ============================================================================
module dtt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_byte,
   input  logic                 req_end,
   input  dtt_pkg::ctl_cmd_type cmd,
   output dtt_pkg::dp_sts_type  sts,
   output dtt_pkg::rsp_item_type gen
);
   import dtt_pkg::*;

   logic [7:0]         held_byte_ff, held_byte_in;
   logic               held_end_ff, held_end_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NUM_LIT-1:0] live_ff, live_in;
   logic [CNT_W-1:0]   rp_ff, rp_in;
   logic [CNT_W-1:0]   rn_ff, rn_in;
   lit_idx_type        rsel_ff, rsel_in;

   logic               replaying;
   logic [7:0]         val_byte;
   logic               val_end;
   logic [NUM_LIT-1:0] hit;
   logic               done_any;
   tok_kind_type       done_kind;
   logic [CNT_W-1:0]   count_nx;

   // Current value: a replayed literal byte or the held item
   assign replaying = rp_ff < rn_ff;
   assign val_byte  = replaying ? lit_char(rsel_ff, rp_ff) : held_byte_ff;
   assign val_end   = !replaying && held_end_ff;
   assign count_nx  = count_ff + 1'b1;

   // Literal matcher: one position per value, all live literals at once
   always_comb begin
      lit_idx_type idx;
      hit       = '0;
      done_any  = 1'b0;
      done_kind = TK_ERROR;
      for (int i = 0; i < NUM_LIT; i++) begin
         idx = lit_idx_type'(i[1:0]);
         hit[i] = live_ff[i] && !val_end && (count_ff < lit_len(idx))
                  && (lit_char(idx, count_ff) == val_byte);
      end
      for (int i = NUM_LIT - 1; i >= 0; i--) begin
         idx = lit_idx_type'(i[1:0]);
         if (hit[i] && (count_nx == lit_len(idx))) begin
            done_any  = 1'b1;
            done_kind = lit_kind(idx);
         end
      end
   end

   // Status to the controller
   always_comb begin
      sts.val_end    = val_end;
      sts.val_ws     = !val_end && ((val_byte == CH_SPACE) ||
                       ((val_byte >= CH_TAB) && (val_byte <= CH_CR)));
      sts.val_lt     = !val_end && (val_byte == CH_LT);
      sts.val_space  = !val_end && (val_byte == CH_SPACE);
      sts.val_rbrace = !val_end && (val_byte == CH_RBRACE);
      sts.val_lf     = !val_end && (val_byte == CH_LF);
      sts.match_hit  = |hit;
      sts.match_done = done_any;
      sts.match_kind = done_kind;
      sts.from_lt    = live_ff[LIT_DICT] || live_ff[LIT_ARRAY];
      sts.replaying  = replaying;
   end

   // Result formed by this step
   always_comb begin
      gen.token_kind = cmd.op.kind;
      unique case (cmd.op.char_sel)
         CS_VALUE: gen.ident_char = val_byte;
         CS_LT:    gen.ident_char = CH_LT;
         default:  gen.ident_char = 8'h00;
      endcase
      gen.char_valid = (cmd.op.char_sel != CS_NONE);
      gen.token_done = (cmd.op.char_sel == CS_NONE);
      gen.last       = cmd.op.consume && !replaying;
   end

   // Next values of held item, partial literal and replay pointer
   always_comb begin
      held_byte_in = held_byte_ff;
      held_end_in  = held_end_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      rp_in        = rp_ff;
      rn_in        = rn_ff;
      rsel_in      = rsel_ff;
      if (cmd.load) begin
         held_byte_in = req_byte;
         held_end_in  = req_end;
      end
      if (cmd.step) begin
         unique case (cmd.op.mop)
            MOP_BEGIN_LT: begin
               count_in = CNT_W'(1);
               live_in  = NUM_LIT'(4'b0011);
            end
            MOP_BEGIN_SP: begin
               count_in = CNT_W'(1);
               live_in  = NUM_LIT'(4'b1100);
            end
            MOP_BEGIN_NOKEY: begin
               count_in = CNT_W'(1);
               live_in  = NUM_LIT'(4'b1000);
            end
            MOP_ADVANCE: begin
               count_in = count_nx;
               live_in  = hit;
            end
            MOP_CLEAR: begin
               count_in = '0;
               live_in  = '0;
            end
            MOP_REPLAY: begin
               // bytes 1..n-1 of the live '<' literal come back in order
               count_in = '0;
               live_in  = '0;
               rp_in    = CNT_W'(1);
               rn_in    = count_ff;
               rsel_in  = live_ff[LIT_DICT] ? LIT_DICT : LIT_ARRAY;
            end
            default: count_in = count_ff;
         endcase
         if (cmd.op.consume && replaying) rp_in = rp_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         live_ff  <= '0;
         rp_ff    <= '0;
         rn_ff    <= '0;
         rsel_ff  <= LIT_DICT;
      end else begin
         count_ff <= count_in;
         live_ff  <= live_in;
         rp_ff    <= rp_in;
         rn_ff    <= rn_in;
         rsel_ff  <= rsel_in;
      end
   end

   // Held item payload
   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      held_end_ff  <= held_end_in;
   end

endmodule

// ----- sv/dtt_rsp_stage.sv -----
// ============================================================================
// dtt_rsp_stage : result staging
// A pending slot keeps the newest result until it is known whether it is the
// last one of its item; an output register then drives the result channel.
// ============================================================================
module dtt_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  gen_valid,
   input  dtt_pkg::rsp_item_type gen,
   input  logic                  mark_last,
   output logic                  stage_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dtt_pkg::rsp_item_type rsp_item
);
   import dtt_pkg::*;

   logic         p_valid_ff, p_valid_in;
   rsp_item_type p_item_ff, p_item_in;
   logic         o_valid_ff, o_valid_in;
   rsp_item_type o_item_ff, o_item_in;
   logic         o_free;
   logic         p_move;

   assign o_free   = !o_valid_ff || rsp_ready;
   // pending result leaves once a newer one arrives or it is marked last, and the output register is free
   assign p_move   = p_valid_ff && o_free && (p_item_ff.last || gen_valid);
   assign stage_ok = !p_valid_ff || o_free;

   always_comb begin
      p_valid_in = p_valid_ff;
      p_item_in  = p_item_ff;
      o_valid_in = o_valid_ff;
      o_item_in  = o_item_ff;
      priority if (p_move) begin
         o_valid_in = 1'b1;
         o_item_in  = p_item_ff;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
      priority if (gen_valid) begin
         p_valid_in = 1'b1;
         p_item_in  = gen;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end else if (mark_last) begin
         p_item_in.last = 1'b1;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_item_ff <= p_item_in;
      o_item_ff <= o_item_in;
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_item  = o_item_ff;

endmodule

// ----- sv/dictionary_text_tokenizer_top.sv -----
// ============================================================================
// dictionary_text_tokenizer_top : dictionary text tokenizer
// Turns a byte stream into dictionary/array/close/colon/newline/no-key tokens
// and byte-wise identifiers, with an end token at the end of the text.
// ============================================================================
// Throughput: one byte per cycle while text flows and rsp keeps up; a '<' literal
//   failing after n bytes first forms the '<' result and n-1 replayed bytes, and
//   an identifier close, a failed space literal and an empty text each form one
//   extra result. Path: held byte, pending slot, output register to rsp; earlier
//   results of an item leave as the next result is formed.
// Reset: synchronous, active high; returns to first-byte check, no clearing pass.
// ============================================================================
module dictionary_text_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] ident_char, [8] token_done, [15:9] zero
   output logic [4:0]  rsp_tuser,   // [3:0] token_kind, [4] char_valid
   output logic        rsp_tlast    // last_result
);
   import dtt_pkg::*;

   ctl_cmd_type  cmd;
   dp_sts_type   sts;
   rsp_item_type gen;
   rsp_item_type rsp_item;
   logic         gen_valid;
   logic         mark_last;
   logic         stage_ok;

   dtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stage_ok  (stage_ok),
      .sts       (sts),
      .cmd       (cmd),
      .gen_valid (gen_valid),
      .mark_last (mark_last)
   );

   dtt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_byte (req_tdata),
      .req_end  (req_tuser[0]),
      .cmd      (cmd),
      .sts      (sts),
      .gen      (gen)
   );

   dtt_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .gen_valid (gen_valid),
      .gen       (gen),
      .mark_last (mark_last),
      .stage_ok  (stage_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // Result channel packing
   assign rsp_tdata = {7'b0, rsp_item.token_done, rsp_item.ident_char};
   assign rsp_tuser = {rsp_item.char_valid, rsp_item.token_kind};
   assign rsp_tlast = rsp_item.last;

endmodule

// ----- sim/tokenizer_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tokenizer_checker : result checker for the dictionary text tokenizer
// Watches both stream channels. Every accepted text byte runs through a local
// model of the scanner, and the tokens it produces queue up in order. Every
// accepted result is compared field by field with the oldest queued token.
// ============================================================================
module tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] ident_char, [8] token_done, [15:9] zero
   input  logic [4:0]  rsp_tuser,   // [3:0] token_kind, [4] char_valid
   input  logic        rsp_tlast,   // last_result
   output int          mismatch_count,
   output int          tokens_pending
);
   import dtt_pkg::*;

   localparam int          TEXT_END   = 256;  // end-of-text marker in the work queue
   localparam int          MAX_TOKENS = 16;   // results one byte may cause
   localparam int          PART_MAX   = 14;   // longest literal
   localparam int          MAX_PRINTS = 100;

   localparam logic [7:0]  ASC_LT     = 8'h3C;
   localparam logic [7:0]  ASC_SPACE  = 8'h20;
   localparam logic [7:0]  ASC_RBRACE = 8'h7D;
   localparam logic [7:0]  ASC_LF     = 8'h0A;

   // Candidate literal set, one bit per literal
   localparam logic [3:0]  LIVE_DICT  = 4'b0001;
   localparam logic [3:0]  LIVE_ARRAY = 4'b0010;
   localparam logic [3:0]  LIVE_COLON = 4'b0100;
   localparam logic [3:0]  LIVE_NOKEY = 4'b1000;

   localparam logic [8*PART_MAX-1:0] PAT_DICT  = "<dictionary> {";
   localparam logic [8*PART_MAX-1:0] PAT_ARRAY = "<array> {";
   localparam logic [8*PART_MAX-1:0] PAT_COLON = " : ";
   localparam logic [8*PART_MAX-1:0] PAT_NOKEY = "  No such key\n";

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   ch;
      logic         cv;
      logic         done;
      logic         last;
   } tok_result_type;

   // Scanner model state
   scan_mode_type  scan_state;
   logic [7:0]     held_bytes [PART_MAX];
   int             held_count;
   logic [3:0]     live_set;

   int unsigned    work_q [$];
   tok_result_type item_tokens [$];
   tok_result_type expected_tokens [$];

   int             errors;
   int             token_serial;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t: token %0d mismatch: %s", $time, token_serial, what);
   endtask

   function automatic logic is_blank(input int unsigned v);
      return v == 32 || (v >= 9 && v <= 13);
   endfunction

   function automatic void literal_info(input lit_idx_type idx,
                                        output logic [8*PART_MAX-1:0] txt,
                                        output int len, output tok_kind_type kd);
      case (idx)
         LIT_DICT:  begin txt = PAT_DICT;  len = 14; kd = TK_DICT;  end
         LIT_ARRAY: begin txt = PAT_ARRAY; len = 9;  kd = TK_ARRAY; end
         LIT_COLON: begin txt = PAT_COLON; len = 3;  kd = TK_COLON; end
         default:   begin txt = PAT_NOKEY; len = 14; kd = TK_NOKEY; end
      endcase
   endfunction

   function automatic void emit_token(input tok_kind_type k, input logic [7:0] ch,
                                      input logic cv, input logic done);
      tok_result_type r;
      if (item_tokens.size() < MAX_TOKENS) begin
         r.kind = k;
         r.ch   = ch;
         r.cv   = cv;
         r.done = done;
         r.last = 1'b0;
         item_tokens.push_back(r);
      end
   endfunction

   function automatic void drop_partial();
      held_count = 0;
      live_set   = '0;
   endfunction

   function automatic void start_partial(input int unsigned v, input logic [3:0] live);
      held_bytes[0] = v[7:0];
      held_count    = 1;
      live_set      = live;
      scan_state    = SM_MATCH;
   endfunction

   function automatic void close_text();
      emit_token(TK_END, 8'h00, 1'b0, 1'b1);
      scan_state = SM_FIRST;
      drop_partial();
   endfunction

   function automatic void token_start(input int unsigned v);
      scan_state = SM_START;
      if (v == ASC_LT) begin
         start_partial(v, LIVE_DICT | LIVE_ARRAY);
      end else if (v == ASC_SPACE) begin
         start_partial(v, LIVE_COLON | LIVE_NOKEY);
      end else if (v == ASC_RBRACE) begin
         emit_token(TK_CLOSE, 8'h00, 1'b0, 1'b1);
      end else if (v == ASC_LF) begin
         emit_token(TK_NEWLINE, 8'h00, 1'b0, 1'b1);
         scan_state = SM_SWALLOW;
      end else if (is_blank(v)) begin
         emit_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
         scan_state = SM_HALT;
      end else begin
         emit_token(TK_IDENT, v[7:0], 1'b1, 1'b0);
         scan_state = SM_IDENT;
      end
   endfunction

   // One byte (or the end marker) against the partial literal
   function automatic void match_step(input int unsigned v);
      int                    n;
      int                    len;
      logic [3:0]            nxt;
      logic [8*PART_MAX-1:0] txt;
      tok_kind_type          kd;
      n   = held_count;
      nxt = '0;
      if (v != TEXT_END && n < PART_MAX) begin
         for (int i = 0; i < 4; i++) begin
            literal_info(lit_idx_type'(i), txt, len, kd);
            if (live_set[i] && n < len && txt[8*(len-1-n) +: 8] == v)
               nxt[i] = 1'b1;
         end
      end
      if (nxt != '0) begin
         held_bytes[n] = v[7:0];
         held_count    = n + 1;
         live_set      = nxt;
         for (int i = 0; i < 4; i++) begin
            literal_info(lit_idx_type'(i), txt, len, kd);
            if (nxt[i] && held_count == len) begin
               emit_token(kd, 8'h00, 1'b0, 1'b1);
               scan_state = SM_START;
               drop_partial();
               return;
            end
         end
         return;
      end
      // failed space literal: stray whitespace
      if (held_bytes[0] != ASC_LT) begin
         emit_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
         scan_state = SM_HALT;
         drop_partial();
         work_q.push_front(v);
         return;
      end
      // failed '<' literal: replay the bytes as an identifier
      work_q.push_front(v);
      for (int i = n - 1; i >= 1; i--)
         work_q.push_front(32'(held_bytes[i]));
      emit_token(TK_IDENT, held_bytes[0], 1'b1, 1'b0);
      scan_state = SM_IDENT;
      drop_partial();
   endfunction

   function automatic void scan_step(input int unsigned v);
      logic at_end;
      at_end = (v == TEXT_END);
      case (scan_state)
         SM_MATCH: match_step(v);
         SM_START: begin
            if (at_end) close_text();
            else        token_start(v);
         end
         SM_SWALLOW: begin
            if (at_end)              close_text();
            else if (!is_blank(v))   token_start(v);
         end
         SM_IDENT: begin
            if (at_end) begin
               emit_token(TK_IDENT, 8'h00, 1'b0, 1'b1);
               close_text();
            end else if (is_blank(v)) begin
               emit_token(TK_IDENT, 8'h00, 1'b0, 1'b1);
               token_start(v);
            end else begin
               emit_token(TK_IDENT, v[7:0], 1'b1, 1'b0);
            end
         end
         SM_HALT: begin
            if (at_end) close_text();
         end
         default: begin
            if (at_end) begin
               emit_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
               close_text();
            end else if (v == ASC_LT) begin
               token_start(v);
            end else if (v == ASC_SPACE) begin
               start_partial(v, LIVE_NOKEY);
            end else begin
               emit_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
               scan_state = SM_HALT;
            end
         end
      endcase
   endfunction

   // Expected tokens for one accepted text transaction
   function automatic void tokenize_byte(input logic [7:0] ch, input logic eot);
      int             guard;
      int unsigned    v;
      tok_result_type r;
      item_tokens.delete();
      work_q.delete();
      work_q.push_back(eot ? TEXT_END : int'(ch));
      guard = 0;
      while (work_q.size() > 0 && guard < 256) begin
         v = work_q.pop_front();
         scan_step(v);
         guard++;
      end
      if (item_tokens.size() > 0) begin
         r      = item_tokens.pop_back();
         r.last = 1'b1;
         item_tokens.push_back(r);
      end
      foreach (item_tokens[i])
         expected_tokens.push_back(item_tokens[i]);
   endfunction

   // Compare results first (they belong to earlier bytes), then predict
   always @(posedge clock) begin
      tok_result_type want;
      if (reset) begin
         scan_state = SM_FIRST;
         drop_partial();
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected result, kind %0d", rsp_tuser[3:0]));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser[3:0] != want.kind)
                  report_mismatch($sformatf("token_kind %0d, want %0d",
                                            rsp_tuser[3:0], want.kind));
               if (rsp_tdata[7:0] != want.ch)
                  report_mismatch($sformatf("ident_char %02h, want %02h",
                                            rsp_tdata[7:0], want.ch));
               if (rsp_tuser[4] != want.cv)
                  report_mismatch($sformatf("char_valid %0b, want %0b",
                                            rsp_tuser[4], want.cv));
               if (rsp_tdata[8] != want.done)
                  report_mismatch($sformatf("token_done %0b, want %0b",
                                            rsp_tdata[8], want.done));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("tlast %0b, want %0b", rsp_tlast, want.last));
               if (rsp_tdata[15:9] != '0)
                  report_mismatch($sformatf("tdata pad bits %02h", rsp_tdata[15:9]));
            end
            token_serial++;
         end
         if (req_tvalid && req_tready)
            tokenize_byte(req_tdata, req_tuser[0]);
      end
      tokens_pending <= expected_tokens.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top : testbench for dictionary_text_tokenizer_top
// Sends a short directed text, then random texts built mostly from valid
// literals, identifiers and newlines with some broken literals and noise.
// Idle patterns on both channels change by phase; the checker scores results.
// ============================================================================
module tb_top;

   localparam int TEXT_ITEMS   = 350;   // target item count, directed included
   localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
   localparam int TAIL_CYCLES  = 4;     // pipeline latency plus margin

   typedef struct packed {
      logic       eot;
      logic [7:0] ch;
   } text_item_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;
   logic [0:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [15:0]   rsp_tdata;
   logic [4:0]    rsp_tuser;
   logic          rsp_tlast;

   int            mismatch_count;
   int            tokens_pending;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            quiet_cycles;
   text_item_type text_items [$];

   string         lit_dict  = "<dictionary> {";
   string         lit_array = "<array> {";
   string         lit_colon = " : ";
   string         lit_nokey = "  No such key\n";

   dictionary_text_tokenizer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tokenizer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on stalled channels
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_byte(input logic [7:0] b);
      text_item_type it;
      it.eot = 1'b0;
      it.ch  = b;
      text_items.push_back(it);
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   // End of text; the data byte is don't-care and random
   task automatic add_end();
      text_item_type it;
      it.eot = 1'b1;
      it.ch  = 8'($urandom_range(255));
      text_items.push_back(it);
   endtask

   // One text: mostly an opening literal, a run of tokens, mostly an end marker
   task automatic add_random_text();
      int          pick;
      int          n_tok;
      int          len;
      logic [7:0]  b;
      string       lit;
      pick = $urandom_range(99);
      if (pick < 45)      add_string(lit_dict);
      else if (pick < 80) add_string(lit_array);
      else if (pick < 90) add_string(lit_nokey);
      else                add_byte(8'($urandom_range(255)));
      n_tok = $urandom_range(12, 2);
      repeat (n_tok) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // identifier: letters mostly, any non-blank byte otherwise
            len = $urandom_range(6, 1);
            repeat (len) begin
               do begin
                  if ($urandom_range(99) < 60) b = 8'(8'h61 + $urandom_range(25));
                  else                          b = 8'($urandom_range(255));
               end while (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
               add_byte(b);
            end
         end else if (pick < 45) begin
            add_string(lit_colon);
         end else if (pick < 62) begin
            // newline plus whitespace to swallow
            add_byte(8'h0A);
            repeat ($urandom_range(4)) begin
               b = 8'($urandom_range(14, 9));
               add_byte(b == 8'h0E ? 8'h20 : b);
            end
         end else if (pick < 72) begin
            add_byte(8'h7D);
         end else if (pick < 80) begin
            pick = $urandom_range(2);
            add_string(pick == 0 ? lit_dict : (pick == 1 ? lit_array : lit_nokey));
         end else if (pick < 88) begin
            // '<' literal broken part way
            lit = $urandom_range(1) ? lit_dict : lit_array;
            len = $urandom_range(lit.len() - 1, 1);
            add_string(lit.substr(0, len - 1));
            add_byte(8'($urandom_range(255)));
         end else if (pick < 94) begin
            // space literal broken part way
            lit = $urandom_range(1) ? lit_colon : lit_nokey;
            len = $urandom_range(lit.len() - 1, 1);
            add_string(lit.substr(0, len - 1));
            add_byte(8'($urandom_range(255)));
         end else begin
            add_byte(8'($urandom_range(255)));
         end
      end
      if ($urandom_range(99) < 92)
         add_end();
   endtask

   task automatic send_text_item(input text_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tuser  <= it.eot;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Hold off the sender until every expected token has been seen
   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      int per_phase;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= '0;
      send_idle_pct = 36;
      recv_idle_pct = 53;

      // Directed: empty text, bad first byte, array with newline swallow
      // and close, stray space, failed '<' literal replayed as identifier
      add_end();
      add_byte(8'hFF);
      add_byte(8'h00);
      add_end();
      add_string(lit_array);
      add_string("\n\t}");
      add_string(" q");
      add_end();
      add_string("<ab");
      add_end();
      while (text_items.size() < TEXT_ITEMS)
         add_random_text();
      add_end();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      per_phase = text_items.size() / 3;
      for (int i = 0; i < text_items.size(); i++) begin
         if (i == per_phase) begin
            drain_tokens();
            send_idle_pct = 53;
            recv_idle_pct = 36;
         end else if (i == 2 * per_phase) begin
            drain_tokens();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_text_item(text_items[i]);
      end
      drain_tokens();

      if (mismatch_count == 0 && tokens_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/dtt_pkg.sv
sv/dtt_ctrl.sv
sv/dtt_datapath.sv
sv/dtt_rsp_stage.sv
sv/dictionary_text_tokenizer_top.sv
sim/tokenizer_checker.sv
sim/tb_top.sv
